// ===== design/pstd_pkg.sv =====
// Shared types and constants for the port scan threshold detector.
`default_nettype none
package pstd_pkg;

    localparam int IDX_W      = 10;  // widest source index
    localparam int HCNT_W     = 17;  // widest per-source host count
    localparam int PCNT_W     = 19;  // widest per-host port count
    localparam int HOST_OUT_W = 11;
    localparam int PORT_OUT_W = 13;

    localparam logic [HOST_OUT_W-1:0] HOST_COUNT_MAX = '1;
    localparam logic [PORT_OUT_W-1:0] PORT_COUNT_MAX = '1;

    localparam logic [HOST_OUT_W-1:0] HOST_THR_RESET = 11'd64;
    localparam logic [PORT_OUT_W-1:0] PORT_THR_RESET = 13'd64;

    localparam logic REG_HOST_THR = 1'b0;
    localparam logic REG_PORT_THR = 1'b1;

    // source key broadcast to every cell
    typedef struct packed {
        logic [31:0] addr;
        logic [1:0]  proto;
    } src_key_t;

    // lookup token walking down the cell row
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [HCNT_W-1:0] hcnt;
        logic [PCNT_W-1:0] maxp;
    } tok_t;

    // entry update broadcast to every cell
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        src_key_t          key;
        logic [HCNT_W-1:0] hcnt;
        logic [PCNT_W-1:0] maxp;
    } cell_wr_t;

endpackage
`default_nettype wire

// ===== design/port_scan_threshold_detector_top.sv =====
// Top level: configuration registers, source cell row and request sequencer.
`default_nettype none
// Port scan threshold detector. One flow request (source, protocol,
// destination, port) is taken at a time and yields one result. The source
// lookup walks a token down a row of SOURCE_ENTRIES cells, one cell per
// cycle. The host and port tables each have one write and one read port.
// Each is scanned one stored entry at a time, a read state then a compare
// state, up to its fill count or the first hit. A finished result waits
// until the previous one has left. Tables are empty after reset with no
// clearing pass. Thresholds are written over the APB port (host at 0x0,
// port at 0x4); the user must write them only while no request is in
// flight, and the block itself does not enforce this.
module port_scan_threshold_detector_top #(
    parameter int SOURCE_ENTRIES = 64,
    parameter int HOST_ENTRIES   = 1024,
    parameter int PORT_ENTRIES   = 4096
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [31:0] s_source_address,
    input  wire  [1:0]  s_protocol_code,
    input  wire  [31:0] s_dest_address,
    input  wire  [15:0] s_dest_port,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_is_scanner,
    output logic        m_any_scanner,
    output logic [10:0] m_host_count,
    output logic [12:0] m_port_count,
    output logic        m_table_overflow,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int HCW = $clog2(HOST_ENTRIES + 1);
    localparam int PCW = $clog2(PORT_ENTRIES + 1);

    logic [10:0] host_thr_reg;
    logic [12:0] port_thr_reg;

    pstd_pkg::src_key_t key;
    pstd_pkg::tok_t     chain [SOURCE_ENTRIES+1];
    pstd_pkg::cell_wr_t wr;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            host_thr_reg <= pstd_pkg::HOST_THR_RESET;
            port_thr_reg <= pstd_pkg::PORT_THR_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                pstd_pkg::REG_HOST_THR: host_thr_reg <= pwdata[10:0];
                pstd_pkg::REG_PORT_THR: port_thr_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            pstd_pkg::REG_HOST_THR: prdata = {21'd0, host_thr_reg};
            pstd_pkg::REG_PORT_THR: prdata = {19'd0, port_thr_reg};
            default:                prdata = 32'd0;
        endcase
        if (paddr[1:0] != 2'd0) begin
            prdata = 32'd0;
        end
    end

    for (genvar i = 0; i < SOURCE_ENTRIES; i++) begin : g_cell
        pstd_cell #(
            .IDX (i),
            .HCW (HCW),
            .PCW (PCW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .key     (key),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1]),
            .wr      (wr)
        );
    end

    pstd_seq #(
        .SOURCE_ENTRIES (SOURCE_ENTRIES),
        .HOST_ENTRIES   (HOST_ENTRIES),
        .PORT_ENTRIES   (PORT_ENTRIES)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_source_address (s_source_address),
        .s_protocol_code  (s_protocol_code),
        .s_dest_address   (s_dest_address),
        .s_dest_port      (s_dest_port),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_scanner     (m_is_scanner),
        .m_any_scanner    (m_any_scanner),
        .m_host_count     (m_host_count),
        .m_port_count     (m_port_count),
        .m_table_overflow (m_table_overflow),
        .host_thr         (host_thr_reg),
        .port_thr         (port_thr_reg),
        .key              (key),
        .tok_launch       (chain[0]),
        .tok_done         (chain[SOURCE_ENTRIES]),
        .wr               (wr)
    );

endmodule
`default_nettype wire

// ===== design/pstd_cell.sv =====
// One source table cell: holds an entry and forwards the lookup token.
`default_nettype none
module pstd_cell #(
    parameter int IDX  = 0,
    parameter int HCW  = 11,
    parameter int PCW  = 13
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  pstd_pkg::src_key_t key,
    input  pstd_pkg::tok_t    tok_in,
    output pstd_pkg::tok_t    tok_out,
    input  pstd_pkg::cell_wr_t wr
);

    logic             valid_reg;
    logic [31:0]      addr_reg;
    logic [1:0]       proto_reg;
    logic [HCW-1:0]   hcnt_reg;
    logic [PCW-1:0]   maxp_reg;
    pstd_pkg::tok_t   tok_reg;
    pstd_pkg::tok_t   tok_next;
    logic             match;

    assign match = valid_reg && addr_reg == key.addr && proto_reg == key.proto;

    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.hit && match) begin
            tok_next.hit  = 1'b1;
            tok_next.idx  = pstd_pkg::IDX_W'(IDX);
            tok_next.hcnt = pstd_pkg::HCNT_W'(hcnt_reg);
            tok_next.maxp = pstd_pkg::PCNT_W'(maxp_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
            if (wr.en && wr.idx == pstd_pkg::IDX_W'(IDX)) begin
                valid_reg <= 1'b1;
            end
        end
        tok_reg.hit  <= tok_next.hit;
        tok_reg.idx  <= tok_next.idx;
        tok_reg.hcnt <= tok_next.hcnt;
        tok_reg.maxp <= tok_next.maxp;
        if (wr.en && wr.idx == pstd_pkg::IDX_W'(IDX)) begin
            addr_reg  <= wr.key.addr;
            proto_reg <= wr.key.proto;
            hcnt_reg  <= wr.hcnt[HCW-1:0];
            maxp_reg  <= wr.maxp[PCW-1:0];
        end
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

// ===== design/pstd_seq.sv =====
// Request sequencer: source lookup via the cell row, host and port table scans.
`default_nettype none
module pstd_seq #(
    parameter int SOURCE_ENTRIES = 64,
    parameter int HOST_ENTRIES   = 1024,
    parameter int PORT_ENTRIES   = 4096
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [31:0] s_source_address,
    input  wire  [1:0]  s_protocol_code,
    input  wire  [31:0] s_dest_address,
    input  wire  [15:0] s_dest_port,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_is_scanner,
    output logic        m_any_scanner,
    output logic [10:0] m_host_count,
    output logic [12:0] m_port_count,
    output logic        m_table_overflow,
    input  wire  [10:0] host_thr,
    input  wire  [12:0] port_thr,
    output pstd_pkg::src_key_t key,
    output pstd_pkg::tok_t     tok_launch,
    input  pstd_pkg::tok_t     tok_done,
    output pstd_pkg::cell_wr_t wr
);

    localparam int SW  = $clog2(SOURCE_ENTRIES);
    localparam int SCW = $clog2(SOURCE_ENTRIES + 1);
    localparam int HW  = $clog2(HOST_ENTRIES);
    localparam int HCW = $clog2(HOST_ENTRIES + 1);
    localparam int PW  = $clog2(PORT_ENTRIES);
    localparam int PCW = $clog2(PORT_ENTRIES + 1);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_LAUNCH = 12'b000000000010,
        S_SRC    = 12'b000000000100,
        S_HRD    = 12'b000000001000,
        S_HCMP   = 12'b000000010000,
        S_HNEW   = 12'b000000100000,
        S_PCNT   = 12'b000001000000,
        S_PSTART = 12'b000010000000,
        S_PRD    = 12'b000100000000,
        S_PCMP   = 12'b001000000000,
        S_PNEW   = 12'b010000000000,
        S_FIN    = 12'b100000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [31:0]     saddr_reg, daddr_reg;
    logic [1:0]      proto_reg;
    logic [15:0]     dport_reg;
    logic [SW-1:0]   sidx_reg, sidx_next;
    logic            src_new_reg, src_new_next;
    logic            srcok_reg, srcok_next;
    logic            hostok_reg, hostok_next;
    logic            hnew_reg, hnew_next;
    logic            ovf_reg, ovf_next;
    logic [HCW-1:0]  hcnt_reg, hcnt_next;
    logic [PCW-1:0]  maxp_reg, maxp_next;
    logic [HW-1:0]   hidx_reg, hidx_next;
    logic [PCW-1:0]  pc_reg, pc_next;
    logic [HCW-1:0]  hscan_reg, hscan_next;
    logic [PCW-1:0]  pscan_reg, pscan_next;
    logic [SCW-1:0]  src_used_reg, src_used_next;
    logic [HCW-1:0]  host_used_reg, host_used_next;
    logic [PCW-1:0]  port_used_reg, port_used_next;
    logic            seen_reg, seen_next;
    logic            m_valid_reg, m_valid_next;
    logic            m_scan_reg, m_scan_next;
    logic [10:0]     m_hc_reg, m_hc_next;
    logic [12:0]     m_pc_reg, m_pc_next;
    logic            m_ovf_reg, m_ovf_next;

    // table memories
    logic [SW+31:0]  hkey_mem [HOST_ENTRIES];
    logic [HW+15:0]  pkey_mem [PORT_ENTRIES];
    logic [PCW-1:0]  pcnt_mem [HOST_ENTRIES];
    logic [SW+31:0]  hkey_q;
    logic [HW+15:0]  pkey_q;
    logic [PCW-1:0]  pcnt_q;

    logic            hk_we, pk_we, pc_we;
    logic [HW-1:0]   pc_waddr;
    logic [PCW-1:0]  pc_wdata;

    logic [PCW-1:0]  maxp_fin;
    logic            scanner;
    logic [31:0]     hc32, pc32;

    always_ff @(posedge aclk) begin
        if (hk_we) begin
            hkey_mem[host_used_reg[HW-1:0]] <= {sidx_reg, daddr_reg};
        end
        if (pk_we) begin
            pkey_mem[port_used_reg[PW-1:0]] <= {hidx_reg, dport_reg};
        end
        if (pc_we) begin
            pcnt_mem[pc_waddr] <= pc_wdata;
        end
        hkey_q <= hkey_mem[hscan_reg[HW-1:0]];
        pkey_q <= pkey_mem[pscan_reg[PW-1:0]];
        pcnt_q <= pcnt_mem[hidx_reg];
    end

    assign key.addr  = saddr_reg;
    assign key.proto = proto_reg;

    always_comb begin
        tok_launch       = '0;
        tok_launch.valid = (state_reg == S_LAUNCH);
    end

    // final tally for the current request
    always_comb begin
        maxp_fin = maxp_reg;
        if (hostok_reg && pc_reg > maxp_reg) begin
            maxp_fin = pc_reg;
        end
        scanner = srcok_reg &&
                  (32'(hcnt_reg) >= 32'(host_thr) ||
                   (hcnt_reg != '0 && 32'(maxp_fin) >= 32'(port_thr)));
        hc32 = srcok_reg ? 32'(hcnt_reg) : 32'd0;
        pc32 = (srcok_reg && hostok_reg) ? 32'(pc_reg) : 32'd0;
    end

    always_comb begin
        state_next     = state_reg;
        sidx_next      = sidx_reg;
        src_new_next   = src_new_reg;
        srcok_next     = srcok_reg;
        hostok_next    = hostok_reg;
        hnew_next      = hnew_reg;
        ovf_next       = ovf_reg;
        hcnt_next      = hcnt_reg;
        maxp_next      = maxp_reg;
        hidx_next      = hidx_reg;
        pc_next        = pc_reg;
        hscan_next     = hscan_reg;
        pscan_next     = pscan_reg;
        src_used_next  = src_used_reg;
        host_used_next = host_used_reg;
        port_used_next = port_used_reg;
        seen_next      = seen_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_scan_next    = m_scan_reg;
        m_hc_next      = m_hc_reg;
        m_pc_next      = m_pc_reg;
        m_ovf_next     = m_ovf_reg;
        hk_we          = 1'b0;
        pk_we          = 1'b0;
        pc_we          = 1'b0;
        pc_waddr       = hidx_reg;
        pc_wdata       = '0;
        wr             = '0;
        s_ready        = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ovf_next    = 1'b0;
                    srcok_next  = 1'b1;
                    hostok_next = 1'b1;
                    state_next  = S_LAUNCH;
                end
            end
            S_LAUNCH: state_next = S_SRC;
            S_SRC: begin
                if (tok_done.valid) begin
                    hscan_next = '0;
                    state_next = (host_used_reg == '0) ? S_HNEW : S_HRD;
                    if (tok_done.hit) begin
                        sidx_next    = tok_done.idx[SW-1:0];
                        hcnt_next    = tok_done.hcnt[HCW-1:0];
                        maxp_next    = tok_done.maxp[PCW-1:0];
                        src_new_next = 1'b0;
                    end else if (32'(src_used_reg) < 32'(SOURCE_ENTRIES)) begin
                        sidx_next    = src_used_reg[SW-1:0];
                        hcnt_next    = '0;
                        maxp_next    = '0;
                        src_new_next = 1'b1;
                    end else begin
                        ovf_next   = 1'b1;
                        srcok_next = 1'b0;
                        state_next = S_FIN;
                    end
                end
            end
            S_HRD: state_next = S_HCMP;
            S_HCMP: begin
                if (hkey_q == {sidx_reg, daddr_reg}) begin
                    hidx_next  = hscan_reg[HW-1:0];
                    hnew_next  = 1'b0;
                    state_next = S_PCNT;
                end else begin
                    hscan_next = hscan_reg + 1'b1;
                    state_next = (hscan_reg + 1'b1 == host_used_reg) ? S_HNEW : S_HRD;
                end
            end
            S_HNEW: begin
                if (32'(host_used_reg) < 32'(HOST_ENTRIES)) begin
                    hk_we          = 1'b1;
                    pc_we          = 1'b1;
                    pc_waddr       = host_used_reg[HW-1:0];
                    hidx_next      = host_used_reg[HW-1:0];
                    host_used_next = host_used_reg + 1'b1;
                    hcnt_next      = hcnt_reg + 1'b1;
                    hnew_next      = 1'b1;
                    state_next     = S_PSTART;
                end else begin
                    ovf_next    = 1'b1;
                    hostok_next = 1'b0;
                    state_next  = S_FIN;
                end
            end
            S_PCNT: state_next = S_PSTART;
            S_PSTART: begin
                pc_next    = hnew_reg ? '0 : pcnt_q;
                pscan_next = '0;
                state_next = (port_used_reg == '0) ? S_PNEW : S_PRD;
            end
            S_PRD: state_next = S_PCMP;
            S_PCMP: begin
                if (pkey_q == {hidx_reg, dport_reg}) begin
                    state_next = S_FIN;
                end else begin
                    pscan_next = pscan_reg + 1'b1;
                    state_next = (pscan_reg + 1'b1 == port_used_reg) ? S_PNEW : S_PRD;
                end
            end
            S_PNEW: begin
                if (32'(port_used_reg) < 32'(PORT_ENTRIES)) begin
                    pk_we          = 1'b1;
                    pc_we          = 1'b1;
                    pc_wdata       = pc_reg + 1'b1;
                    pc_next        = pc_reg + 1'b1;
                    port_used_next = port_used_reg + 1'b1;
                end else begin
                    ovf_next = 1'b1;
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    if (srcok_reg) begin
                        wr.en   = 1'b1;
                        wr.idx  = pstd_pkg::IDX_W'(sidx_reg);
                        wr.key  = key;
                        wr.hcnt = pstd_pkg::HCNT_W'(hcnt_reg);
                        wr.maxp = pstd_pkg::PCNT_W'(maxp_fin);
                        if (src_new_reg) begin
                            src_used_next = src_used_reg + 1'b1;
                        end
                    end
                    seen_next    = seen_reg | scanner;
                    m_valid_next = 1'b1;
                    m_scan_next  = scanner;
                    m_hc_next    = (hc32 > 32'(pstd_pkg::HOST_COUNT_MAX)) ?
                                   pstd_pkg::HOST_COUNT_MAX : hc32[10:0];
                    m_pc_next    = (pc32 > 32'(pstd_pkg::PORT_COUNT_MAX)) ?
                                   pstd_pkg::PORT_COUNT_MAX : pc32[12:0];
                    m_ovf_next   = ovf_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            src_used_reg  <= '0;
            host_used_reg <= '0;
            port_used_reg <= '0;
            seen_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            src_used_reg  <= src_used_next;
            host_used_reg <= host_used_next;
            port_used_reg <= port_used_next;
            seen_reg      <= seen_next;
            m_valid_reg   <= m_valid_next;
        end
        if (s_valid && s_ready) begin
            saddr_reg <= s_source_address;
            proto_reg <= s_protocol_code;
            daddr_reg <= s_dest_address;
            dport_reg <= s_dest_port;
        end
        sidx_reg    <= sidx_next;
        src_new_reg <= src_new_next;
        srcok_reg   <= srcok_next;
        hostok_reg  <= hostok_next;
        hnew_reg    <= hnew_next;
        ovf_reg     <= ovf_next;
        hcnt_reg    <= hcnt_next;
        maxp_reg    <= maxp_next;
        hidx_reg    <= hidx_next;
        pc_reg      <= pc_next;
        hscan_reg   <= hscan_next;
        pscan_reg   <= pscan_next;
        m_scan_reg  <= m_scan_next;
        m_hc_reg    <= m_hc_next;
        m_pc_reg    <= m_pc_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_is_scanner     = m_scan_reg;
    assign m_any_scanner    = seen_reg;
    assign m_host_count     = m_hc_reg;
    assign m_port_count     = m_pc_reg;
    assign m_table_overflow = m_ovf_reg;

`ifndef SYNTHESIS
    a_src_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(src_used_reg) <= 32'(SOURCE_ENTRIES))
        else $error("source fill count past table depth");
    a_host_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(host_used_reg) <= 32'(HOST_ENTRIES))
        else $error("host fill count past table depth");
    a_port_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(port_used_reg) <= 32'(PORT_ENTRIES))
        else $error("port fill count past table depth");
    a_tok_one: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_done.valid |-> state_reg == S_SRC)
        else $error("lookup token returned outside source lookup");
    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(seen_reg) && $past(aresetn) |-> seen_reg)
        else $error("any-scanner flag dropped");
`endif

endmodule
`default_nettype wire
